[rtl/core/rbi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rbi_pkg;

    // Coordinate format: signed, COORD_W bits, FRAC_BITS fraction bits.
    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DIST_W     = 31;
    localparam int TOL_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Divider geometry: shifted numerator magnitude and quotient width.
    localparam int NUM_W = COORD_W + 2 + FRAC_BITS;
    localparam int QUO_W = DIST_W;

    localparam logic [DIST_W-1:0] MAX_LENGTH_RESET = {DIST_W{1'b1}};
    localparam logic [TOL_W-1:0]  TOLERANCE_RESET  = TOL_W'(66);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_LENGTH = CFG_IDX_W'(0),
        REG_TOLERANCE  = CFG_IDX_W'(1)
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic signed [COORD_W-1:0] box_x;
        logic signed [COORD_W-1:0] box_y;
        logic signed [COORD_W-1:0] box_z;
        logic [COORD_W-2:0]        box_width;
        logic [COORD_W-2:0]        box_height;
        logic [COORD_W-2:0]        box_depth;
    } in_payload_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } out_payload_t;

endpackage

`default_nettype wire

[rtl/core/rbi_div_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbi_div_pipe (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [rbi_pkg::NUM_W-1:0] num,
    input  wire logic [rbi_pkg::COORD_W-1:0] den,
    output logic [rbi_pkg::QUO_W-1:0]      quo,
    output logic                           ovf
);
    import rbi_pkg::*;

    localparam int CMP_W = COORD_W + QUO_W;

    logic [NUM_W-1:0]   rem_reg [0:QUO_W-1];
    logic [COORD_W-1:0] den_reg [0:QUO_W-1];
    logic [QUO_W-1:0]   quo_reg [0:QUO_W];
    logic               ovf_reg [0:QUO_W];
    logic [CMP_W:0]     diff    [1:QUO_W];

    // Trial subtraction of the shifted divisor, one quotient bit per stage.
    always_comb begin
        for (int k = 1; k <= QUO_W; k++) begin
            diff[k] = {1'b0, CMP_W'(rem_reg[k-1])}
                    - ({1'b0, CMP_W'(den_reg[k-1])} << (QUO_W - k));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Quotient would not fit in QUO_W bits.
            ovf_reg[0] <= {1'b0, CMP_W'(num)} >= {1'b0, den, {QUO_W{1'b0}}};
            rem_reg[0] <= num;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            for (int k = 1; k <= QUO_W; k++) begin
                ovf_reg[k] <= ovf_reg[k-1];
                quo_reg[k] <= quo_reg[k-1]
                            | (diff[k][CMP_W] ? '0 : (QUO_W'(1) << (QUO_W - k)));
            end
            for (int k = 1; k < QUO_W; k++) begin
                den_reg[k] <= den_reg[k-1];
                rem_reg[k] <= diff[k][CMP_W] ? rem_reg[k-1] : diff[k][NUM_W-1:0];
            end
        end
    end

    assign quo = quo_reg[QUO_W];
    assign ovf = ovf_reg[QUO_W];

endmodule

`default_nettype wire

[rtl/core/ray_box_intersection.sv]
// Throughput: one request per cycle; the whole pipeline stalls only when the
// output register holds a result that is not taken.
// The divide is a 32-stage restoring pipeline: an entry stage, then one quotient bit per stage.
// Reset (aresetn low, synchronous) empties the pipeline and loads
// max_length = 0x7FFFFFFF and tolerance = 66.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_intersection (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire rbi_pkg::in_payload_t          s_payload,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output rbi_pkg::out_payload_t              m_payload,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rbi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbi_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rbi_pkg::*;

    localparam int DIV_LAT = QUO_W + 1;
    localparam int PROD_W  = DIST_W + COORD_W;
    localparam int P_W     = PROD_W - FRAC_BITS + 2;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] org;
        logic [2:0][COORD_W-1:0] dir;
        logic [2:0][COORD_W-1:0] lo;
        logic [2:0][COORD_W:0]   hi;
        logic [5:0]              skip;
    } item_t;

    typedef struct packed {
        logic              ok;
        logic [DIST_W-1:0] t;
    } cand_t;

    function automatic cand_t pick_min(input cand_t a, input cand_t b);
        if (a.ok && (!b.ok || a.t <= b.t)) begin
            return a;
        end
        return b;
    endfunction

    logic              adv;
    logic [DIST_W-1:0] max_len_reg;
    logic [TOL_W-1:0]  tol_reg;

    // Pipeline advances whenever the output register is free or being taken.
    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LENGTH_RESET;
            tol_reg     <= TOLERANCE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_LENGTH: max_len_reg <= cfg_data[DIST_W-1:0];
                REG_TOLERANCE:  tol_reg     <= cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits travel with the data.
    logic v1_reg, v2_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic vdl_reg [0:DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            m_valid <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) begin
                vdl_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            v1_reg     <= s_valid;
            v2_reg     <= v1_reg;
            vdl_reg[0] <= v2_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                vdl_reg[i] <= vdl_reg[i-1];
            end
            v4_reg  <= vdl_reg[DIV_LAT-1];
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            m_valid <= v7_reg;
        end
    end

    // Stage 1: request register.
    in_payload_t in_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg <= s_payload;
        end
    end

    // Stage 2: face planes, numerators and skip conditions.
    item_t                  d2_next;
    logic [NUM_W-1:0]       nnum_next [0:5];
    logic [COORD_W-1:0]     dmag_next [0:5];
    logic [COORD_W-2:0]     size_c    [0:2];
    logic [COORD_W:0]       plane_c;
    logic [COORD_W+1:0]     num_c;
    logic [COORD_W+1:0]     nmag_c;
    logic [COORD_W-1:0]     dax_c;
    logic                   nneg_c;
    logic                   dneg_c;

    always_comb begin
        d2_next.org[0] = in_reg.origin_x;
        d2_next.org[1] = in_reg.origin_y;
        d2_next.org[2] = in_reg.origin_z;
        d2_next.dir[0] = in_reg.dir_x;
        d2_next.dir[1] = in_reg.dir_y;
        d2_next.dir[2] = in_reg.dir_z;
        d2_next.lo[0]  = in_reg.box_x;
        d2_next.lo[1]  = in_reg.box_y;
        d2_next.lo[2]  = in_reg.box_z;
        size_c[0]      = in_reg.box_width;
        size_c[1]      = in_reg.box_height;
        size_c[2]      = in_reg.box_depth;
        for (int a = 0; a < 3; a++) begin
            d2_next.hi[a] = {d2_next.lo[a][COORD_W-1], d2_next.lo[a]}
                          + {2'b00, size_c[a]};
        end
        plane_c = '0;
        num_c   = '0;
        nmag_c  = '0;
        dax_c   = '0;
        nneg_c  = 1'b0;
        dneg_c  = 1'b0;
        for (int f = 0; f < 6; f++) begin
            if (f < 3) begin
                plane_c = {d2_next.lo[f][COORD_W-1], d2_next.lo[f]};
                dax_c   = d2_next.dir[f];
                num_c   = {plane_c[COORD_W], plane_c}
                        - {{2{d2_next.org[f][COORD_W-1]}}, d2_next.org[f]};
            end else begin
                plane_c = d2_next.hi[f-3];
                dax_c   = d2_next.dir[f-3];
                num_c   = {plane_c[COORD_W], plane_c}
                        - {{2{d2_next.org[f-3][COORD_W-1]}}, d2_next.org[f-3]};
            end
            nneg_c  = num_c[COORD_W+1];
            dneg_c  = dax_c[COORD_W-1];
            nmag_c  = nneg_c ? -num_c : num_c;
            // A face is dropped on a zero direction or when t would be negative.
            d2_next.skip[f] = (dax_c == '0) || ((num_c != '0) && (nneg_c != dneg_c));
            nnum_next[f]    = {nmag_c, {FRAC_BITS{1'b0}}};
            dmag_next[f]    = dneg_c ? -dax_c : dax_c;
        end
    end

    item_t              d2_reg;
    logic [NUM_W-1:0]   nnum2_reg [0:5];
    logic [COORD_W-1:0] dmag2_reg [0:5];

    always_ff @(posedge aclk) begin
        if (adv) begin
            d2_reg <= d2_next;
            for (int f = 0; f < 6; f++) begin
                nnum2_reg[f] <= nnum_next[f];
                dmag2_reg[f] <= dmag_next[f];
            end
        end
    end

    // Six parallel divider pipelines, one per face.
    logic [QUO_W-1:0] quo_w [0:5];
    logic             ovf_w [0:5];

    for (genvar g = 0; g < 6; g++) begin : g_div
        rbi_div_pipe u_div (
            .aclk (aclk),
            .en   (adv),
            .num  (nnum2_reg[g]),
            .den  (dmag2_reg[g]),
            .quo  (quo_w[g]),
            .ovf  (ovf_w[g])
        );
    end

    // Item data follows the dividers.
    item_t dl_reg [0:DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            dl_reg[0] <= d2_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    // Stage 4: range check on t.
    item_t d4_reg;
    cand_t c4_reg [0:5];

    always_ff @(posedge aclk) begin
        if (adv) begin
            d4_reg <= dl_reg[DIV_LAT-1];
            for (int f = 0; f < 6; f++) begin
                c4_reg[f].t  <= quo_w[f];
                c4_reg[f].ok <= !dl_reg[DIV_LAT-1].skip[f] && !ovf_w[f]
                              && (quo_w[f] <= max_len_reg);
            end
        end
    end

    // Stage 5: t times the direction magnitude on the two other axes.
    logic [PROD_W-1:0]  prod_next [0:5][0:2];
    logic [COORD_W-1:0] dm5_c [0:2];

    always_comb begin
        for (int b = 0; b < 3; b++) begin
            dm5_c[b] = d4_reg.dir[b][COORD_W-1] ? -d4_reg.dir[b] : d4_reg.dir[b];
        end
        for (int f = 0; f < 6; f++) begin
            for (int b = 0; b < 3; b++) begin
                if (b == f || b == f - 3) begin
                    prod_next[f][b] = '0;
                end else begin
                    prod_next[f][b] = PROD_W'(c4_reg[f].t) * PROD_W'(dm5_c[b]);
                end
            end
        end
    end

    item_t             d5_reg;
    cand_t             c5_reg   [0:5];
    logic [PROD_W-1:0] prod_reg [0:5][0:2];

    always_ff @(posedge aclk) begin
        if (adv) begin
            d5_reg <= d4_reg;
            for (int f = 0; f < 6; f++) begin
                c5_reg[f] <= c4_reg[f];
                for (int b = 0; b < 3; b++) begin
                    prod_reg[f][b] <= prod_next[f][b];
                end
            end
        end
    end

    // Stage 6: hit point and containment in the widened box.
    cand_t                c6_next [0:5];
    logic signed [P_W-1:0] ext_c;
    logic signed [P_W-1:0] pt_c;
    logic signed [P_W-1:0] lo_tol_c;
    logic signed [P_W-1:0] hi_tol_c;
    logic                  inside_c;

    always_comb begin
        ext_c    = '0;
        pt_c     = '0;
        lo_tol_c = '0;
        hi_tol_c = '0;
        for (int f = 0; f < 6; f++) begin
            inside_c = 1'b1;
            for (int b = 0; b < 3; b++) begin
                if (b != f && b != f - 3) begin
                    ext_c = P_W'(prod_reg[f][b][PROD_W-1:FRAC_BITS]);
                    if (d5_reg.dir[b][COORD_W-1]) begin
                        ext_c = -ext_c;
                    end
                    pt_c = {{(P_W-COORD_W){d5_reg.org[b][COORD_W-1]}}, d5_reg.org[b]}
                         + ext_c;
                    lo_tol_c = {{(P_W-COORD_W){d5_reg.lo[b][COORD_W-1]}}, d5_reg.lo[b]}
                             - P_W'(tol_reg);
                    hi_tol_c = {{(P_W-COORD_W-1){d5_reg.hi[b][COORD_W]}}, d5_reg.hi[b]}
                             + P_W'(tol_reg);
                    if (pt_c < lo_tol_c || pt_c > hi_tol_c) begin
                        inside_c = 1'b0;
                    end
                end
            end
            c6_next[f].t  = c5_reg[f].t;
            c6_next[f].ok = c5_reg[f].ok && inside_c;
        end
    end

    cand_t c6_reg [0:5];
    cand_t c7_reg [0:2];
    cand_t best_c;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int f = 0; f < 6; f++) begin
                c6_reg[f] <= c6_next[f];
            end
            // Stage 7: first level of the minimum tree.
            for (int i = 0; i < 3; i++) begin
                c7_reg[i] <= pick_min(c6_reg[2*i], c6_reg[2*i+1]);
            end
        end
    end

    // Stage 8: last level of the minimum tree into the output register.
    assign best_c = pick_min(pick_min(c7_reg[0], c7_reg[1]), c7_reg[2]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_payload.hit      <= best_c.ok;
            m_payload.distance <= best_c.ok ? best_c.t : '0;
        end
    end

endmodule

`default_nettype wire

[rtl/core/rbi_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbi_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire rbi_pkg::in_payload_t          s_payload,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire rbi_pkg::out_payload_t         m_payload,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [rbi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbi_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rbi_pkg::*;

    // Reset empties the result channel.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The input side is held only by an unaccepted result.
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid |-> (s_ready == (!m_valid || m_ready)))
        else $error("request stalled without output back-pressure");

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // A miss reports zero distance.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.hit |-> m_payload.distance == '0)
        else $error("miss with nonzero distance");

endmodule

bind ray_box_intersection rbi_checker u_rbi_checker (.*);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import rbi_pkg::*;

    localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG = CFG_IDX_W'(15);
    localparam int STALL_LIMIT = 20000;
    localparam int LATENCY = 38;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_payload_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_payload_t m_payload;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copies of the two registers.
    logic [DIST_W-1:0] max_len_q = MAX_LENGTH_RESET;
    logic [TOL_W-1:0] tol_q = TOLERANCE_RESET;

    out_payload_t hit_queue[$];
    int src_idle = 0;
    int sink_stall = 0;
    int hold_cnt = 0;
    int errors = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_hits = 0;
    int quiet_cycles = 0;

    ray_box_intersection i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Expected hit flag and nearest face distance for one ray and box.
    function automatic out_payload_t nearest_hit(in_payload_t it);
        longint org[3], dir[3], lo[3], hi[3];
        longint num, sh, t, p, plane, best, tol;
        longint unsigned m, mt, md, pr;
        bit hit, in_box;
        int ax;
        out_payload_t r;
        org[0] = it.origin_x; org[1] = it.origin_y; org[2] = it.origin_z;
        dir[0] = it.dir_x; dir[1] = it.dir_y; dir[2] = it.dir_z;
        lo[0] = it.box_x; lo[1] = it.box_y; lo[2] = it.box_z;
        hi[0] = lo[0] + longint'({33'b0, it.box_width});
        hi[1] = lo[1] + longint'({33'b0, it.box_height});
        hi[2] = lo[2] + longint'({33'b0, it.box_depth});
        tol = longint'({48'b0, tol_q});
        hit = 1'b0;
        best = 0;
        for (int f = 0; f < 6; f++) begin
            ax = f % 3;
            plane = (f < 3) ? lo[ax] : hi[ax];
            if (dir[ax] == 0) continue;
            num = plane - org[ax];
            // A face behind the origin is dropped even if the quotient truncates to zero.
            if (num != 0 && ((num < 0) != (dir[ax] < 0))) continue;
            m = (num < 0) ? -num : num;
            if (m > (SAT_MAX >>> FRAC_BITS)) sh = SAT_MAX;
            else sh = longint'(m << FRAC_BITS);
            if (num < 0) sh = -sh;
            t = sh / dir[ax];
            if (t < 0 || t > longint'({33'b0, max_len_q})) continue;
            in_box = 1'b1;
            for (int b = 0; b < 3; b++) begin
                if (b == ax) begin
                    p = plane;
                end else begin
                    mt = t;
                    md = (dir[b] < 0) ? -dir[b] : dir[b];
                    if (md != 0 && mt > longint'(SAT_MAX) / md) pr = SAT_MAX;
                    else pr = mt * md;
                    pr = pr >> FRAC_BITS;
                    p = org[b] + ((dir[b] < 0) ? -longint'(pr) : longint'(pr));
                end
                if (p < lo[b] - tol || p > hi[b] + tol) in_box = 1'b0;
            end
            if (!in_box) continue;
            if (!hit || t < best) best = t;
            hit = 1'b1;
        end
        r.hit = hit;
        r.distance = hit ? best[DIST_W-1:0] : '0;
        return r;
    endfunction

    function automatic in_payload_t mk_ray(longint ox, longint oy, longint oz,
                                           longint dx, longint dy, longint dz,
                                           longint bx, longint by, longint bz,
                                           longint w, longint h, longint d);
        in_payload_t it;
        it.origin_x = ox[31:0]; it.origin_y = oy[31:0]; it.origin_z = oz[31:0];
        it.dir_x = dx[31:0]; it.dir_y = dy[31:0]; it.dir_z = dz[31:0];
        it.box_x = bx[31:0]; it.box_y = by[31:0]; it.box_z = bz[31:0];
        it.box_width = w[30:0]; it.box_height = h[30:0]; it.box_depth = d[30:0];
        return it;
    endfunction

    function automatic longint rand_span(int bits);
        return longint'($urandom_range((1 << bits) - 1)) - longint'(1 << (bits - 1));
    endfunction

    // Mostly rays aimed at the box with random jitter; the rest raw bit noise.
    function automatic in_payload_t rand_ray();
        in_payload_t it;
        logic [12*32-1:0] raw;
        longint o[3], c[3], lo[3], sz[3], dv[3];
        int bits;
        if ($urandom_range(99) < 20) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            it = raw[$bits(in_payload_t)-1:0];
            return it;
        end
        bits = $urandom_range(22, 12);
        for (int a = 0; a < 3; a++) begin
            o[a] = rand_span(bits);
            lo[a] = rand_span(bits);
            sz[a] = $urandom_range((1 << (bits - 1)) - 1);
            c[a] = lo[a] + sz[a] / 2;
            dv[a] = c[a] - o[a];
            if ($urandom_range(3) == 0) dv[a] = dv[a] + rand_span(bits - 2);
            if ($urandom_range(9) == 0) dv[a] = 0;
            if ($urandom_range(9) == 0) dv[a] = dv[a] / longint'($urandom_range(64, 2));
        end
        return mk_ray(o[0], o[1], o[2], dv[0], dv[1], dv[2],
                      lo[0], lo[1], lo[2], sz[0], sz[1], sz[2]);
    endfunction

    // Predict every accepted request at the edge that takes it.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            hit_queue.push_back(nearest_hit(s_payload));
            n_requests++;
        end
    end

    // Result sink with random stalls and an optional long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall);
        end
    end

    // Result checker and stall watchdog.
    always @(posedge aclk) begin
        out_payload_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (hit_queue.size() == 0) begin
                $display("%0t: unexpected result hit=%0b distance=%h",
                         $time, m_payload.hit, m_payload.distance);
                errors++;
            end else begin
                exp_r = hit_queue.pop_front();
                if (exp_r.hit) n_hits++;
                if (m_payload.hit !== exp_r.hit) begin
                    $display("%0t: hit expected %0b actual %0b",
                             $time, exp_r.hit, m_payload.hit);
                    errors++;
                end
                if (m_payload.distance !== exp_r.distance) begin
                    $display("%0t: distance expected %h actual %h",
                             $time, exp_r.distance, m_payload.distance);
                    errors++;
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired with %0d results pending",
                     $time, hit_queue.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_ray(in_payload_t it);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_MAX_LENGTH) max_len_q = val[DIST_W-1:0];
        else if (idx == REG_TOLERANCE) tol_q = val[TOL_W-1:0];
    endtask

    task automatic test_directed();
        longint one;
        one = 1 << FRAC_BITS;
        // Straight along each axis, in both senses along x.
        send_ray(mk_ray(0, 0, 0, one, 0, 0, 10 * one, -one, -one, one, 2 * one, 2 * one));
        send_ray(mk_ray(20 * one, 0, 0, -one, 0, 0, 10 * one, -one, -one, one, 2 * one, 2 * one));
        send_ray(mk_ray(0, 0, 0, 0, one, 0, -one, 5 * one, -one, 2 * one, one, 2 * one));
        send_ray(mk_ray(0, 0, 0, 0, 0, -one, -one, -one, -9 * one, 2 * one, 2 * one, one));
        // Zero direction, then a diagonal ray, origin inside the box.
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, -one, -one, -one, 2 * one, 2 * one, 2 * one));
        send_ray(mk_ray(0, 0, 0, one, one, one, -one, -one, -one, 2 * one, 2 * one, 2 * one));
        // Origin on a face plane gives t of zero.
        send_ray(mk_ray(0, 0, 0, one, 0, 0, 0, -one, -one, one, 2 * one, 2 * one));
        // Face just behind the origin whose quotient would truncate to zero.
        send_ray(mk_ray(1, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, -one, -one, 0, 2 * one, 2 * one));
        // Ray pointing away from the box.
        send_ray(mk_ray(0, 0, 0, -one, 0, 0, 10 * one, -one, -one, one, 2 * one, 2 * one));
        // Hit point exactly at the widened edge, and one past it.
        send_ray(mk_ray(0, 2 * one + 66, 0, one, 0, 0, 4 * one, 0, 0, one, 2 * one, one));
        send_ray(mk_ray(0, 2 * one + 67, 0, one, 0, 0, 4 * one, 0, 0, one, 2 * one, one));
        send_ray(mk_ray(0, -66, 0, one, 0, 0, 4 * one, 0, 0, one, one, one));
        // Extremes of every field.
        send_ray(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                        -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_ray(mk_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
        send_ray(mk_ray(-64'sd2147483648, 0, 0, 1, 1, -1,
                        32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_ray(mk_ray(0, 0, 0, 1, 0, 0, 32'h7FFF, 0, 0, 0, 0, 0));
        send_ray(mk_ray(0, 0, 0, -1, -1, -1, -64'sd2147483648, -64'sd2147483648,
                        -64'sd2147483648, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_ray('1);
        send_ray('0);
        wait_drained();
    endtask

    task automatic test_random(int count, int idle, int stall);
        src_idle = idle;
        sink_stall = stall;
        for (int i = 0; i < count; i++) send_ray(rand_ray());
        wait_drained();
    endtask

    // Long sink hold-off while the source keeps pushing, then a full drain.
    task automatic test_backpressure();
        src_idle = 0;
        sink_stall = 0;
        hold_cnt = 400;
        for (int i = 0; i < 90; i++) send_ray(rand_ray());
        wait_drained();
    endtask

    task automatic test_registers();
        write_reg(REG_MAX_LENGTH, '0);
        write_reg(REG_TOLERANCE, '0);
        test_directed();
        test_random(60, 20, 20);
        write_reg(REG_MAX_LENGTH, CFG_DATA_W'(4 << FRAC_BITS));
        write_reg(REG_TOLERANCE, CFG_DATA_W'(TOL_W'('1)));
        test_random(60, 0, 0);
        write_reg(REG_MAX_LENGTH, $urandom);
        write_reg(REG_TOLERANCE, $urandom);
        // Writes to an index outside the map must leave both registers alone.
        write_reg(UNUSED_REG, $urandom);
        test_random(60, 30, 30);
        write_reg(REG_MAX_LENGTH, 32'hFFFF_FFFF);
        write_reg(REG_TOLERANCE, CFG_DATA_W'(TOLERANCE_RESET));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(85, 0, 0);
        test_random(85, 45, 0);
        test_random(85, 0, 45);
        test_random(85, 38, 38);
        test_backpressure();
        test_registers();
        test_directed();
        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Checked %0d ray-box requests against %0d results, %0d of them hits,",
                 n_requests, n_results, n_hits);
        $display("across register settings, idle/stall mixes and a long sink hold-off.");
        if (errors == 0 && hit_queue.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
